// File: rtl/tadu_pkg.sv
// Shared types and constants for the two-adic arithmetic unit.
// No dependencies; every other file of the unit refers to this package.
package tadu_pkg;

    localparam int WORD_BITS    = 64;
    localparam int SIG_BITS_DEF = 57;
    localparam int EXP_BITS_DEF = 7;
    localparam int SHAMT_W      = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_NEG = 2'd2,
        CMD_MUL = 2'd3
    } cmd_t;

    // Load enables of the pipeline stages behind the input register.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_ld_t;

    // Alignment and operation flags handed from operand preparation to the add path.
    typedef struct packed {
        logic shift_a;
        logic shift_b;
        logic big;
        logic neg_op;
    } add_ctl_t;

endpackage

// File: rtl/tadu_prep.sv
// Operand preparation stage: unpacks both words, aligns exponents for add,
// forms magnitudes for multiply and the negated word. Uses tadu_pkg.
module tadu_prep #(
    parameter int SIG_BITS = tadu_pkg::SIG_BITS_DEF,
    parameter int EXP_BITS = tadu_pkg::EXP_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               ld_en,
    input  tadu_pkg::cmd_t                     cmd,
    input  logic [tadu_pkg::WORD_BITS-1:0]     operand_a,
    input  logic [tadu_pkg::WORD_BITS-1:0]     operand_b,
    output logic [SIG_BITS-1:0]                sa_reg,
    output logic [SIG_BITS-1:0]                sb_reg,
    output tadu_pkg::add_ctl_t                 ctl_reg,
    output logic [tadu_pkg::SHAMT_W-1:0]       shamt_reg,
    output logic [EXP_BITS-1:0]                emin_reg,
    output logic [tadu_pkg::WORD_BITS-1:0]     neg_word_reg,
    output logic [SIG_BITS-1:0]                ma_reg,
    output logic [SIG_BITS-1:0]                mb_reg,
    output logic                               mneg_reg,
    output logic [EXP_BITS-1:0]                ep_reg
);

    localparam int EXP_FIELD = (EXP_BITS < tadu_pkg::WORD_BITS - SIG_BITS) ?
                               EXP_BITS : tadu_pkg::WORD_BITS - SIG_BITS;

    logic signed [EXP_BITS-1:0] exp_a;
    logic signed [EXP_BITS-1:0] exp_b;
    logic signed [EXP_BITS:0]   dab;
    logic signed [EXP_BITS:0]   dba;
    logic                       a_gt;
    logic                       b_gt;
    logic [EXP_BITS-1:0]        diff;
    logic [SIG_BITS-1:0]        a_raw;
    logic [SIG_BITS-1:0]        b_raw;
    logic [SIG_BITS-1:0]        neg_b;
    logic [SIG_BITS-1:0]        neg_a;
    tadu_pkg::add_ctl_t         ctl_next;

    assign exp_a = EXP_BITS'(operand_a[SIG_BITS +: EXP_FIELD]);
    assign exp_b = EXP_BITS'(operand_b[SIG_BITS +: EXP_FIELD]);
    assign dab   = (EXP_BITS+1)'(exp_a) - (EXP_BITS+1)'(exp_b);
    assign dba   = (EXP_BITS+1)'(exp_b) - (EXP_BITS+1)'(exp_a);
    assign a_gt  = exp_a > exp_b;
    assign b_gt  = exp_b > exp_a;
    assign diff  = a_gt ? dab[EXP_BITS-1:0] : dba[EXP_BITS-1:0];

    assign a_raw = operand_a[SIG_BITS-1:0];
    assign b_raw = operand_b[SIG_BITS-1:0];
    assign neg_a = ~a_raw + 1'b1;
    assign neg_b = ~b_raw + 1'b1;

    always_comb begin
        ctl_next.shift_a = a_gt;
        ctl_next.shift_b = b_gt;
        ctl_next.big     = 32'(diff) >= 32'd64;
        ctl_next.neg_op  = (cmd == tadu_pkg::CMD_NEG);
    end

    always_ff @(posedge aclk) begin
        if (ld_en) begin
            sa_reg       <= a_raw;
            sb_reg       <= (cmd == tadu_pkg::CMD_SUB) ? neg_b : b_raw;
            ctl_reg      <= ctl_next;
            shamt_reg    <= tadu_pkg::SHAMT_W'(diff);
            emin_reg     <= a_gt ? exp_b : exp_a;
            neg_word_reg <= tadu_pkg::WORD_BITS'({operand_b[SIG_BITS +: EXP_FIELD], neg_b});
            ma_reg       <= a_raw[SIG_BITS-1] ? neg_a : a_raw;
            mb_reg       <= b_raw[SIG_BITS-1] ? neg_b : b_raw;
            mneg_reg     <= a_raw[SIG_BITS-1] ^ b_raw[SIG_BITS-1];
            ep_reg       <= exp_a + exp_b;
        end
    end

endmodule

// File: rtl/tadu_add_path.sv
// Add, subtract and negate path: aligned sum, trailing-zero count, normalize
// and pack over three register stages. Uses tadu_pkg.
module tadu_add_path #(
    parameter int SIG_BITS = tadu_pkg::SIG_BITS_DEF,
    parameter int EXP_BITS = tadu_pkg::EXP_BITS_DEF
) (
    input  logic                               aclk,
    input  tadu_pkg::pipe_ld_t                 ld,
    input  logic [SIG_BITS-1:0]                sa,
    input  logic [SIG_BITS-1:0]                sb,
    input  tadu_pkg::add_ctl_t                 ctl,
    input  logic [tadu_pkg::SHAMT_W-1:0]       shamt,
    input  logic [EXP_BITS-1:0]                emin,
    input  logic [tadu_pkg::WORD_BITS-1:0]     neg_word,
    output logic [tadu_pkg::WORD_BITS-1:0]     add_word_reg
);

    localparam int WB        = tadu_pkg::WORD_BITS;
    localparam int EXP_FIELD = (EXP_BITS < WB - SIG_BITS) ? EXP_BITS : WB - SIG_BITS;
    localparam int TZ_W      = $clog2(SIG_BITS);

    logic [WB-1:0]       sa64;
    logic [WB-1:0]       sb64;
    logic [WB-1:0]       al_a;
    logic [WB-1:0]       al_b;
    logic [WB-1:0]       sum_s2_reg;
    logic [EXP_BITS-1:0] exp_s2_reg;
    logic                neg_s2_reg;
    logic [TZ_W-1:0]     tz;
    logic [WB-1:0]       sum_s3_reg;
    logic [TZ_W-1:0]     tz_s3_reg;
    logic                zero_s3_reg;
    logic [EXP_BITS-1:0] exp_s3_reg;
    logic                neg_s3_reg;
    logic [WB-1:0]       shifted;
    logic [EXP_BITS-1:0] exp_norm;
    logic [WB-1:0]       add_word_next;

    assign sa64 = {{(WB-SIG_BITS){sa[SIG_BITS-1]}}, sa};
    assign sb64 = {{(WB-SIG_BITS){sb[SIG_BITS-1]}}, sb};
    assign al_a = ctl.shift_a ? (ctl.big ? '0 : sa64 << shamt) : sa64;
    assign al_b = ctl.shift_b ? (ctl.big ? '0 : sb64 << shamt) : sb64;

    always_ff @(posedge aclk) begin
        if (ld.s2) begin
            sum_s2_reg <= ctl.neg_op ? neg_word : al_a + al_b;
            exp_s2_reg <= emin;
            neg_s2_reg <= ctl.neg_op;
        end
    end

    // The shift stops at the top significand bit when no lower bit is set.
    always_comb begin
        tz = TZ_W'(SIG_BITS-1);
        for (int i = SIG_BITS-2; i >= 0; i--) begin
            if (sum_s2_reg[i]) begin
                tz = TZ_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.s3) begin
            sum_s3_reg  <= sum_s2_reg;
            tz_s3_reg   <= tz;
            zero_s3_reg <= (sum_s2_reg == '0);
            exp_s3_reg  <= exp_s2_reg;
            neg_s3_reg  <= neg_s2_reg;
        end
    end

    assign shifted  = sum_s3_reg >> tz_s3_reg;
    assign exp_norm = exp_s3_reg + EXP_BITS'(tz_s3_reg);

    always_comb begin
        if (neg_s3_reg) begin
            add_word_next = sum_s3_reg;
        end else if (zero_s3_reg) begin
            add_word_next = '0;
        end else begin
            add_word_next = WB'({exp_norm[EXP_FIELD-1:0], shifted[SIG_BITS-1:0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.s4) begin
            add_word_reg <= add_word_next;
        end
    end

endmodule

// File: rtl/tadu_mul_path.sv
// Multiply path: four half-width partial products, product sum, trailing-zero
// count, then normalize, sign and pack into the result. Uses tadu_pkg.
module tadu_mul_path #(
    parameter int SIG_BITS = tadu_pkg::SIG_BITS_DEF,
    parameter int EXP_BITS = tadu_pkg::EXP_BITS_DEF
) (
    input  logic                               aclk,
    input  tadu_pkg::pipe_ld_t                 ld,
    input  logic [SIG_BITS-1:0]                ma,
    input  logic [SIG_BITS-1:0]                mb,
    input  logic                               mneg,
    input  logic [EXP_BITS-1:0]                ep,
    output logic [tadu_pkg::WORD_BITS-1:0]     mul_word
);

    localparam int WB        = tadu_pkg::WORD_BITS;
    localparam int EXP_FIELD = (EXP_BITS < WB - SIG_BITS) ? EXP_BITS : WB - SIG_BITS;
    localparam int HALF      = (SIG_BITS + 1) / 2;
    localparam int HI_W      = SIG_BITS - HALF;
    localparam int PROD_W    = 2 * SIG_BITS;
    localparam int PTZ_W     = $clog2(PROD_W);

    logic [2*HALF-1:0]      p00_reg;
    logic [SIG_BITS-1:0]    p01_reg;
    logic [SIG_BITS-1:0]    p10_reg;
    logic [2*HI_W-1:0]      p11_reg;
    logic                   neg_s2_reg;
    logic [EXP_BITS-1:0]    exp_s2_reg;
    logic [SIG_BITS:0]      mid;
    logic [PROD_W-1:0]      prod_s3_reg;
    logic                   neg_s3_reg;
    logic [EXP_BITS-1:0]    exp_s3_reg;
    logic [PTZ_W-1:0]       tz;
    logic [PROD_W-1:0]      prod_s4_reg;
    logic [PTZ_W-1:0]       tz_s4_reg;
    logic                   neg_s4_reg;
    logic [EXP_BITS-1:0]    exp_s4_reg;
    logic [PROD_W-1:0]      shifted;
    logic [SIG_BITS-1:0]    sig_mag;
    logic [SIG_BITS-1:0]    sig_out;
    logic [EXP_BITS-1:0]    exp_out;

    always_ff @(posedge aclk) begin
        if (ld.s2) begin
            p00_reg    <= (2*HALF)'(ma[HALF-1:0]) * (2*HALF)'(mb[HALF-1:0]);
            p01_reg    <= SIG_BITS'(ma[HALF-1:0]) * SIG_BITS'(mb[SIG_BITS-1:HALF]);
            p10_reg    <= SIG_BITS'(ma[SIG_BITS-1:HALF]) * SIG_BITS'(mb[HALF-1:0]);
            p11_reg    <= (2*HI_W)'(ma[SIG_BITS-1:HALF]) * (2*HI_W)'(mb[SIG_BITS-1:HALF]);
            neg_s2_reg <= mneg;
            exp_s2_reg <= ep;
        end
    end

    assign mid = (SIG_BITS+1)'(p01_reg) + (SIG_BITS+1)'(p10_reg);

    always_ff @(posedge aclk) begin
        if (ld.s3) begin
            prod_s3_reg <= {p11_reg, p00_reg} + (PROD_W'(mid) << HALF);
            neg_s3_reg  <= neg_s2_reg;
            exp_s3_reg  <= exp_s2_reg;
        end
    end

    // A zero product keeps a shift of zero.
    always_comb begin
        tz = '0;
        for (int i = PROD_W-1; i >= 0; i--) begin
            if (prod_s3_reg[i]) begin
                tz = PTZ_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.s4) begin
            prod_s4_reg <= prod_s3_reg;
            tz_s4_reg   <= tz;
            neg_s4_reg  <= neg_s3_reg;
            exp_s4_reg  <= exp_s3_reg;
        end
    end

    assign shifted  = prod_s4_reg >> tz_s4_reg;
    assign sig_mag  = shifted[SIG_BITS-1:0];
    assign sig_out  = neg_s4_reg ? ~sig_mag + 1'b1 : sig_mag;
    assign exp_out  = exp_s4_reg + EXP_BITS'(tz_s4_reg);
    assign mul_word = WB'({exp_out[EXP_FIELD-1:0], sig_out});

endmodule

// File: rtl/two_adic_57_7_arith_unit_core.sv
// Top level of the two-adic arithmetic unit: input register, stage control,
// result register. Depends on tadu_pkg, tadu_prep, tadu_add_path, tadu_mul_path.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_cmd, s_operand_a, s_operand_b
//  m_      | out       | m_valid / m_ready  | m_result_word
//
// One operation is accepted per cycle while results are taken; a result is registered in
// prep, path and result stages, a depth set by the split multiplier and trailing-zero stages.
// Every stage moves on when the one behind it is empty or moving, so bubbles close up.
// When the result is not taken, s_ready drops only once all six registers hold items.
// Reset is synchronous and active low and empties the pipeline.
module two_adic_57_7_arith_unit_core #(
    parameter int SIG_BITS = tadu_pkg::SIG_BITS_DEF,
    parameter int EXP_BITS = tadu_pkg::EXP_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [tadu_pkg::WORD_BITS-1:0]  s_operand_a,
    input  logic [tadu_pkg::WORD_BITS-1:0]  s_operand_b,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tadu_pkg::WORD_BITS-1:0]  m_result_word
);

    localparam int WB        = tadu_pkg::WORD_BITS;
    localparam int EXP_FIELD = (EXP_BITS < WB - SIG_BITS) ? EXP_BITS : WB - SIG_BITS;
    localparam int PACK_BITS = SIG_BITS + EXP_FIELD;

    logic [5:0]                   valid_reg;
    logic [5:0]                   valid_next;
    logic                         ld0;
    tadu_pkg::pipe_ld_t           ld;
    tadu_pkg::cmd_t               cmd_reg;
    logic [WB-1:0]                a_reg;
    logic [WB-1:0]                b_reg;
    logic [4:1]                   mul_reg;
    logic [WB-1:0]                result_word_reg;

    logic [SIG_BITS-1:0]          sa;
    logic [SIG_BITS-1:0]          sb;
    tadu_pkg::add_ctl_t           add_ctl;
    logic [tadu_pkg::SHAMT_W-1:0] shamt;
    logic [EXP_BITS-1:0]          emin;
    logic [WB-1:0]                neg_word;
    logic [SIG_BITS-1:0]          ma;
    logic [SIG_BITS-1:0]          mb;
    logic                         mneg;
    logic [EXP_BITS-1:0]          ep;
    logic [WB-1:0]                add_word;
    logic [WB-1:0]                mul_word;

    always_comb begin
        ld.s5 = !valid_reg[5] || m_ready;
        ld.s4 = !valid_reg[4] || ld.s5;
        ld.s3 = !valid_reg[3] || ld.s4;
        ld.s2 = !valid_reg[2] || ld.s3;
        ld.s1 = !valid_reg[1] || ld.s2;
        ld0   = !valid_reg[0] || ld.s1;
    end

    always_comb begin
        valid_next[0] = ld0   ? s_valid      : valid_reg[0];
        valid_next[1] = ld.s1 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = ld.s2 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = ld.s3 ? valid_reg[2] : valid_reg[3];
        valid_next[4] = ld.s4 ? valid_reg[3] : valid_reg[4];
        valid_next[5] = ld.s5 ? valid_reg[4] : valid_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            cmd_reg <= tadu_pkg::cmd_t'(s_cmd);
            a_reg   <= s_operand_a;
            b_reg   <= s_operand_b;
        end
        if (ld.s1) begin
            mul_reg[1] <= (cmd_reg == tadu_pkg::CMD_MUL);
        end
        if (ld.s2) begin
            mul_reg[2] <= mul_reg[1];
        end
        if (ld.s3) begin
            mul_reg[3] <= mul_reg[2];
        end
        if (ld.s4) begin
            mul_reg[4] <= mul_reg[3];
        end
        if (ld.s5) begin
            result_word_reg <= mul_reg[4] ? mul_word : add_word;
        end
    end

    tadu_prep #(
        .SIG_BITS (SIG_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_prep (
        .aclk         (aclk),
        .ld_en        (ld.s1),
        .cmd          (cmd_reg),
        .operand_a    (a_reg),
        .operand_b    (b_reg),
        .sa_reg       (sa),
        .sb_reg       (sb),
        .ctl_reg      (add_ctl),
        .shamt_reg    (shamt),
        .emin_reg     (emin),
        .neg_word_reg (neg_word),
        .ma_reg       (ma),
        .mb_reg       (mb),
        .mneg_reg     (mneg),
        .ep_reg       (ep)
    );

    tadu_add_path #(
        .SIG_BITS (SIG_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_add_path (
        .aclk         (aclk),
        .ld           (ld),
        .sa           (sa),
        .sb           (sb),
        .ctl          (add_ctl),
        .shamt        (shamt),
        .emin         (emin),
        .neg_word     (neg_word),
        .add_word_reg (add_word)
    );

    tadu_mul_path #(
        .SIG_BITS (SIG_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_mul_path (
        .aclk     (aclk),
        .ld       (ld),
        .ma       (ma),
        .mb       (mb),
        .mneg     (mneg),
        .ep       (ep),
        .mul_word (mul_word)
    );

    assign s_ready       = ld0;
    assign m_valid       = valid_reg[5];
    assign m_result_word = result_word_reg;

    // Input back-pressure only ever comes from a stalled, fully occupied pipeline.
    a_no_early_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the pipeline could still move");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Bits above the exponent field of a packed word are always zero.
    a_pack_high_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_result_word >> PACK_BITS) == '0))
        else $error("result word has bits set above the exponent field");

endmodule

// File: tb/two_adic_57_7_result_checker.sv
// Result checker for the two-adic arithmetic unit: watches both channels, predicts
// each packed result word and compares it with what the unit returns.
// Depends on tadu_pkg for the operation codes and word layout.
`timescale 1ns / 1ps

module two_adic_57_7_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [tadu_pkg::WORD_BITS-1:0]  s_operand_a,
    input  logic [tadu_pkg::WORD_BITS-1:0]  s_operand_b,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [tadu_pkg::WORD_BITS-1:0]  m_result_word,
    output int                              mismatches,
    output int                              outstanding,
    output int                              checked
);

    localparam int SB = tadu_pkg::SIG_BITS_DEF;
    localparam int EB = tadu_pkg::EXP_BITS_DEF;
    localparam int W  = tadu_pkg::WORD_BITS;

    typedef logic [W-1:0] word_t;

    localparam word_t SIG_MASK = (word_t'(1) << SB) - 1;

    word_t result_q[$];

    function automatic word_t sig_sext(word_t w);
        return word_t'($signed(w[SB-1:0]));
    endfunction

    function automatic int exp_of(word_t w);
        return int'($signed(w[SB +: EB]));
    endfunction

    function automatic word_t pack_word(int e, word_t s);
        word_t r = '0;
        r[SB +: EB] = e[EB-1:0];
        r[SB-1:0]   = s[SB-1:0];
        return r;
    endfunction

    function automatic word_t negate_word(word_t b);
        return pack_word(exp_of(b), -b);
    endfunction

    function automatic word_t add_words(word_t a, word_t b);
        int    ea;
        int    eb;
        int    re;
        int    sh;
        word_t sig_a;
        word_t sig_b;
        word_t total;
        ea    = exp_of(a);
        eb    = exp_of(b);
        sig_a = sig_sext(a);
        sig_b = sig_sext(b);
        re    = ea;
        if (ea > eb) begin
            sig_a = (ea - eb >= W) ? '0 : sig_a << (ea - eb);
            re    = eb;
        end else if (eb > ea) begin
            sig_b = (eb - ea >= W) ? '0 : sig_b << (eb - ea);
        end
        total = sig_a + sig_b;
        if (total == '0)
            return '0;
        sh = 0;
        while (sh < SB - 1 && !total[sh])
            sh++;
        return pack_word(re + sh, total >> sh);
    endfunction

    function automatic word_t predict_result(tadu_pkg::cmd_t op, word_t a, word_t b);
        word_t          sig_a;
        word_t          sig_b;
        word_t          mag_a;
        word_t          mag_b;
        word_t          frac;
        logic [2*W-1:0] prod;
        int             tz;
        case (op)
            tadu_pkg::CMD_ADD: return add_words(a, b);
            tadu_pkg::CMD_SUB: return add_words(a, negate_word(b));
            tadu_pkg::CMD_NEG: return negate_word(b);
            default: ;
        endcase
        // Multiply in sign-magnitude and strip the trailing zeros of the full product.
        sig_a = sig_sext(a);
        sig_b = sig_sext(b);
        mag_a = (sig_a[W-1] ? -sig_a : sig_a) & SIG_MASK;
        mag_b = (sig_b[W-1] ? -sig_b : sig_b) & SIG_MASK;
        prod  = {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
        tz    = 0;
        if (prod != '0) begin
            while (!prod[tz])
                tz++;
        end
        frac = word_t'(prod >> tz);
        if (sig_a[W-1] != sig_b[W-1])
            frac = -frac;
        return pack_word(exp_of(a) + exp_of(b) + tz, frac);
    endfunction

    always @(posedge aclk) begin
        word_t want;
        if (!aresetn) begin
            result_q.delete();
            outstanding <= 0;
            mismatches  <= 0;
            checked     <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, m_result_word);
                    mismatches <= mismatches + 1;
                end else begin
                    want = result_q.pop_front();
                    checked <= checked + 1;
                    if (m_result_word !== want) begin
                        $display("%0t: result_word mismatch, expected %h, got %h",
                                 $time, want, m_result_word);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                result_q.push_back(predict_result(tadu_pkg::cmd_t'(s_cmd),
                                                  s_operand_a, s_operand_b));
            outstanding <= result_q.size();
        end
    end

endmodule

// File: tb/two_adic_57_7_arith_unit_core_tb.sv
// Testbench top for two_adic_57_7_arith_unit_core: drives operations and result
// back-pressure, and gives the verdict from the result checker's counts.
// Depends on tadu_pkg, the unit's RTL and two_adic_57_7_result_checker.
`timescale 1ns / 1ps

module two_adic_57_7_arith_unit_core_tb;

    localparam int SB           = tadu_pkg::SIG_BITS_DEF;
    localparam int EB           = tadu_pkg::EXP_BITS_DEF;
    localparam int WORD_BITS    = tadu_pkg::WORD_BITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [SB-1:0] SIG_MIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic [SB-1:0] SIG_MAXP = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SIG_ONES = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_cmd;
    logic [WORD_BITS-1:0] s_operand_a;
    logic [WORD_BITS-1:0] s_operand_b;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_BITS-1:0] m_result_word;

    int mismatches;
    int outstanding;
    int checked;
    int cycles;
    int op_count[4];
    bit gaps_on;
    bit stalls_on;
    bit hold_req;

    two_adic_57_7_arith_unit_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word)
    );

    two_adic_57_7_result_checker u_result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.", cycles, outstanding);
        $display("CHECKS FAILED");
        $finish;
    end

    // The result side stalls in random bursts, or for one long stretch on request.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [WORD_BITS-1:0] word_of(int e, logic [SB-1:0] s);
        return {e[EB-1:0], s};
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        logic [SB-1:0] sig;
        int            e;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: sig = SB'({$urandom(), $urandom()});
            4, 5:       sig = SB'({$urandom(), $urandom()}) << $urandom_range(0, SB - 1);
            6:          sig = SB'($urandom_range(0, 16)) - SB'(8);
            7: begin
                case ($urandom_range(0, 4))
                    0:       sig = '0;
                    1:       sig = SB'(1);
                    2:       sig = SIG_ONES;
                    3:       sig = SIG_MIN;
                    default: sig = SIG_MAXP;
                endcase
            end
            default: begin
                sig = SB'({$urandom(), $urandom()}) >> $urandom_range(0, SB - 1);
                if ($urandom_range(0, 1) == 1)
                    sig = -sig;
            end
        endcase
        case ($urandom_range(0, 7))
            0:       e = $urandom_range(0, (1 << EB) - 1);
            1:       e = ($urandom_range(0, 1) == 1) ? (1 << (EB - 1)) - 1 : -(1 << (EB - 1));
            default: e = $urandom_range(0, 8) - 4;
        endcase
        return word_of(e, sig);
    endfunction

    task automatic send_item(tadu_pkg::cmd_t op, logic [WORD_BITS-1:0] a,
                             logic [WORD_BITS-1:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        op_count[op]++;
    endtask

    task automatic send_random(int count);
        tadu_pkg::cmd_t       op;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        repeat (count) begin
            op = tadu_pkg::cmd_t'($urandom_range(0, 3));
            a  = rand_word();
            b  = rand_word();
            case ($urandom_range(0, 9))
                0:       b = a;
                1:       b = {a[WORD_BITS-1:SB], -a[SB-1:0]};
                2:       b[WORD_BITS-1:SB] = a[WORD_BITS-1:SB] + EB'($urandom_range(0, 3));
                default: ;
            endcase
            send_item(op, a, b);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_cmd       <= tadu_pkg::CMD_ADD;
        s_operand_a <= '0;
        s_operand_b <= '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        hold_req  = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero sums, wide alignment, the normalization cap, the most negative significand, negates and multiplies.
        send_item(tadu_pkg::CMD_ADD, '0, '0);
        send_item(tadu_pkg::CMD_ADD, '1, '1);
        send_item(tadu_pkg::CMD_SUB, '1, '1);
        send_item(tadu_pkg::CMD_ADD, word_of(5, SB'(123)), word_of(5, -SB'(123)));
        send_item(tadu_pkg::CMD_ADD, word_of(63, SB'(1)), word_of(-64, SB'(1)));
        send_item(tadu_pkg::CMD_ADD, word_of(-64, SB'(3)), word_of(63, SB'(5)));
        send_item(tadu_pkg::CMD_ADD, word_of(63, SB'(1)), word_of(0, SB'(1)));
        send_item(tadu_pkg::CMD_ADD, word_of(0, SIG_MIN), word_of(0, '0));
        send_item(tadu_pkg::CMD_SUB, word_of(2, SIG_MIN), word_of(2, SIG_MAXP));
        send_item(tadu_pkg::CMD_ADD, word_of(3, SIG_MAXP), word_of(3, SIG_MAXP));
        send_item(tadu_pkg::CMD_ADD, word_of(10, SB'(6)), word_of(10, SB'(10)));
        send_item(tadu_pkg::CMD_SUB, word_of(-1, SB'(1) << 40),
                  word_of(-3, -(SB'(1) << 20)));
        send_item(tadu_pkg::CMD_NEG, '0, word_of(0, SIG_MIN));
        send_item(tadu_pkg::CMD_NEG, '1, '0);
        send_item(tadu_pkg::CMD_NEG, '0, '1);
        send_item(tadu_pkg::CMD_NEG, '1, word_of(-64, SIG_MAXP));
        send_item(tadu_pkg::CMD_MUL, word_of(7, '0), word_of(9, SB'(12345)));
        send_item(tadu_pkg::CMD_MUL, word_of(63, SIG_MIN), word_of(63, SIG_MIN));
        send_item(tadu_pkg::CMD_MUL, word_of(-64, SIG_MIN), word_of(1, SIG_ONES));
        send_item(tadu_pkg::CMD_MUL, word_of(0, SIG_MAXP), word_of(0, SIG_MAXP));
        send_item(tadu_pkg::CMD_MUL, '1, '1);
        send_item(tadu_pkg::CMD_MUL, '0, '0);
        send_item(tadu_pkg::CMD_MUL, word_of(0, SB'(1) << 30),
                  word_of(0, -(SB'(1) << 40)));

        send_random(600);

        // Hold the result side off while operations keep coming so the pipeline backs up.
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_random(40);
        wait_drained();

        gaps_on   = 1'b1;
        stalls_on = 1'b0;
        send_random(200);
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        send_random(200);
        wait_drained();

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random(460);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d add, %0d subtract, %0d negate and %0d multiply operations.",
                 op_count[tadu_pkg::CMD_ADD], op_count[tadu_pkg::CMD_SUB],
                 op_count[tadu_pkg::CMD_NEG], op_count[tadu_pkg::CMD_MUL]);
        $display("Compared %0d result words with %0d mismatches.", checked, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
